[src/bglk_pkg.sv]
// ---------------------------------------------------------------------------
// Beam endpoint grid lookup package
// Shared types, register indexes and the quarter-wave sine table.
// ---------------------------------------------------------------------------
package bglk_pkg;

   localparam logic [2:0] REG_OFFSET_X    = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
   localparam logic [2:0] REG_START_ANGLE = 3'd2;
   localparam logic [2:0] REG_ANGLE_STEP  = 3'd3;
   localparam logic [2:0] REG_CELLS_PER_M = 3'd4;
   localparam logic [2:0] REG_GRID_WIDTH  = 3'd5;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd6;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_BEAM = 1'b1;

   localparam int QTR_STEPS = 256;
   localparam longint COS_STEP_Q30 = 64'sd1073721611;
   localparam longint SIN_STEP_Q30 = 64'sd6588356;

   typedef struct packed {
      logic        valid;
      logic        action;
      logic [15:0] cell_index;
      logic [7:0]  cell_value;
      logic [11:0] beam_index;
      logic [23:0] beam_range;
   } meta_type;

   typedef struct packed {
      logic [16:0] s0;
      logic [16:0] s1;
      logic [5:0]  frac;
      logic        neg;
   } trig_tap_type;

   typedef logic [16:0] sine_tab_type [0:QTR_STEPS];

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      longint prev;
      longint cur;
      longint nxt;
      longint q16;
      prev = 0;
      cur = SIN_STEP_Q30;
      tab[0] = 17'd0;
      for (int k = 1; k <= QTR_STEPS; k++) begin
         q16 = (cur + (64'sd1 <<< 13)) >>> 14;
         if (q16 > 65536) q16 = 65536;
         if (q16 < 0) q16 = 0;
         tab[k] = q16[16:0];
         nxt = ((COS_STEP_Q30 * cur + (64'sd1 <<< 28)) >>> 29) - prev;
         prev = cur;
         cur = nxt;
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

[src/bglk_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bglk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/bglk_trig.sv]
// ---------------------------------------------------------------------------
// Beam angle and sine/cosine
// Three stages: angle, table fetch, interpolation with sign.
// ---------------------------------------------------------------------------
module bglk_trig
   import bglk_pkg::*;
#(
   parameter int MAX_BEAMS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  meta_type           meta_in,
   input  logic [15:0]        start_angle,
   input  logic signed [15:0] angle_step,
   output meta_type           meta_out,
   output logic signed [18:0] cos_out,
   output logic signed [18:0] sin_out
);

   localparam int BEAM_W = $clog2(MAX_BEAMS);

   meta_type           meta1_ff, meta2_ff, meta3_ff;
   logic [15:0]        ang1_ff;
   logic [15:0]        ang1_in;
   logic [11:0]        bidx_wrap;
   trig_tap_type       tap_c_ff, tap_s_ff;
   logic signed [18:0] cos_ff, sin_ff;

   function automatic trig_tap_type fetch(input logic [15:0] a);
      trig_tap_type t;
      logic [14:0]  q;
      logic [8:0]   idx;
      q = {1'b0, a[13:0]};
      if (a[14]) q = 15'd16384 - q;
      idx = q[14:6];
      t.neg = a[15];
      if (idx >= 9'(QTR_STEPS)) begin
         t.s0 = SINE_TAB[QTR_STEPS];
         t.s1 = SINE_TAB[QTR_STEPS];
         t.frac = 6'd0;
      end else begin
         t.s0 = SINE_TAB[idx];
         t.s1 = SINE_TAB[idx + 9'd1];
         t.frac = q[5:0];
      end
      return t;
   endfunction

   function automatic logic signed [18:0] interp(input trig_tap_type t);
      logic signed [17:0] d;
      logic signed [24:0] p;
      logic signed [18:0] v;
      d = $signed({1'b0, t.s1}) - $signed({1'b0, t.s0});
      p = 25'(d) * $signed({19'd0, t.frac}) + 25'sd32;
      v = $signed({2'b00, t.s0}) + 19'(p >>> 6);
      return t.neg ? -v : v;
   endfunction

   assign bidx_wrap = (BEAM_W >= 12) ? meta_in.beam_index
                                     : (meta_in.beam_index & 12'(MAX_BEAMS - 1));
   assign ang1_in = start_angle + 16'({4'd0, bidx_wrap} * angle_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         meta1_ff.valid <= 1'b0;
         meta2_ff.valid <= 1'b0;
         meta3_ff.valid <= 1'b0;
      end else if (en) begin
         meta1_ff <= meta_in;
         meta2_ff <= meta1_ff;
         meta3_ff <= meta2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang1_ff <= ang1_in;
         tap_c_ff <= fetch(ang1_ff + 16'd16384);
         tap_s_ff <= fetch(ang1_ff);
         cos_ff <= interp(tap_c_ff);
         sin_ff <= interp(tap_s_ff);
      end
   end

   assign meta_out = meta3_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

[src/bglk_project.sv]
// ---------------------------------------------------------------------------
// Endpoint projection
// Four stages: range times trig, offset add, scale to cells, bound check.
// ---------------------------------------------------------------------------
module bglk_project
   import bglk_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  meta_type                              meta_in,
   input  logic signed [18:0]                    cos_in,
   input  logic signed [18:0]                    sin_in,
   input  logic signed [31:0]                    offset_x,
   input  logic signed [31:0]                    offset_y,
   input  logic [23:0]                           cells_per_meter,
   input  logic [$clog2(GRID_SIDE+1)-1:0]        dim_w,
   input  logic [$clog2(GRID_SIDE+1)-1:0]        dim_h,
   output meta_type                              meta_out,
   output logic [$clog2(GRID_SIDE)-1:0]          col_out,
   output logic [$clog2(GRID_SIDE)-1:0]          row_out,
   output logic                                  inside_out
);

   localparam int DIM_W = $clog2(GRID_SIDE + 1);
   localparam int SIDE_W = $clog2(GRID_SIDE);

   meta_type           meta4_ff, meta5_ff, meta6_ff, meta7_ff;
   logic signed [43:0] px4_ff, py4_ff;
   logic signed [33:0] pos_x5_ff, pos_y5_ff;
   logic signed [58:0] gx6_ff, gy6_ff;
   logic signed [28:0] mi_in, mj_in;
   logic [SIDE_W-1:0]  col7_ff, row7_ff;
   logic               inside7_ff;
   logic               inside_in;

   function automatic logic signed [33:0] place(input logic signed [43:0] p,
                                                input logic signed [31:0] off);
      logic signed [43:0] r;
      r = (p + 44'sd32768) >>> 16;
      return 34'(off) + 34'(r);
   endfunction

   function automatic logic signed [28:0] grid_coord(input logic signed [58:0] g,
                                                     input logic [DIM_W-1:0] dim);
      logic signed [58:0] r;
      r = (g + (59'sd1 <<< 31)) >>> 32;
      return 29'(r) + $signed(29'(dim >> 1));
   endfunction

   assign mi_in = grid_coord(gx6_ff, dim_w);
   assign mj_in = grid_coord(gy6_ff, dim_h);
   assign inside_in = (mi_in >= 0) && (mi_in < $signed(29'(dim_w)))
                   && (mj_in >= 0) && (mj_in < $signed(29'(dim_h)));

   always_ff @(posedge clock) begin
      if (reset) begin
         meta4_ff.valid <= 1'b0;
         meta5_ff.valid <= 1'b0;
         meta6_ff.valid <= 1'b0;
         meta7_ff.valid <= 1'b0;
      end else if (en) begin
         meta4_ff <= meta_in;
         meta5_ff <= meta4_ff;
         meta6_ff <= meta5_ff;
         meta7_ff <= meta6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px4_ff <= 44'($signed({1'b0, meta_in.beam_range})) * 44'(cos_in);
         py4_ff <= 44'($signed({1'b0, meta_in.beam_range})) * 44'(sin_in);
         pos_x5_ff <= place(px4_ff, offset_x);
         pos_y5_ff <= place(py4_ff, offset_y);
         gx6_ff <= 59'(pos_x5_ff) * 59'($signed({1'b0, cells_per_meter}));
         gy6_ff <= 59'(pos_y5_ff) * 59'($signed({1'b0, cells_per_meter}));
         col7_ff <= mi_in[SIDE_W-1:0];
         row7_ff <= mj_in[SIDE_W-1:0];
         inside7_ff <= inside_in;
      end
   end

   assign meta_out = meta7_ff;
   assign col_out = col7_ff;
   assign row_out = row7_ff;
   assign inside_out = inside7_ff;

endmodule

[src/beam_endpoint_grid_lookup.sv]
// ---------------------------------------------------------------------------
// Beam endpoint grid lookup
// Projects lidar beam endpoints into an occupancy grid and returns the cell.
// ---------------------------------------------------------------------------
// The block takes one beat per cycle unless the output stalls; an accepted
// request passes three angle and sine stages, four projection stages, the
// grid memory read and the output register. Load beats write one grid cell
// and give no response; beam beats give one response each. The grid memory
// is not cleared at reset, so the whole grid must be loaded before beams
// are sent. MAX_BEAMS must be a power of two. The user must write
// configuration only while no beat is in flight; the block does not check.
module beam_endpoint_grid_lookup
   import bglk_pkg::*;
#(
   parameter int GRID_SIDE = 256,
   parameter int MAX_BEAMS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_index[15:0], cell_value[23:16], beam_index[35:24], beam_range[59:36]
   input  logic [63:0] req_tdata,
   // action[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // beam_number[11:0], occupancy[19:12], inside_grid[20]
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int DIM_W = $clog2(GRID_SIDE + 1);
   localparam int SIDE_W = $clog2(GRID_SIDE);
   localparam int DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic signed [31:0] offset_x_ff, offset_y_ff;
   logic [15:0]        start_angle_ff;
   logic signed [15:0] angle_step_ff;
   logic [23:0]        cells_per_m_ff;
   logic [8:0]         grid_width_ff, grid_height_ff;
   logic [DIM_W-1:0]   dim_w, dim_h;

   logic               en;
   meta_type           meta_in, meta3, meta7, meta8_ff;
   logic signed [18:0] cos_v, sin_v;
   logic [SIDE_W-1:0]  col7, row7;
   logic               inside7, inside8_ff;
   logic [ADDR_W-1:0]  raddr;
   logic               load_we;
   logic [7:0]         ram_q;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_data_ff;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         start_angle_ff <= '0;
         angle_step_ff <= '0;
         cells_per_m_ff <= 24'd65536;
         grid_width_ff <= 9'd256;
         grid_height_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OFFSET_X:    offset_x_ff <= csr_wdata;
            REG_OFFSET_Y:    offset_y_ff <= csr_wdata;
            REG_START_ANGLE: start_angle_ff <= csr_wdata[15:0];
            REG_ANGLE_STEP:  angle_step_ff <= csr_wdata[15:0];
            REG_CELLS_PER_M: cells_per_m_ff <= csr_wdata[23:0];
            REG_GRID_WIDTH:  grid_width_ff <= csr_wdata[8:0];
            REG_GRID_HEIGHT: grid_height_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign dim_w = (32'(grid_width_ff) > GRID_SIDE) ? DIM_W'(GRID_SIDE) : DIM_W'(grid_width_ff);
   assign dim_h = (32'(grid_height_ff) > GRID_SIDE) ? DIM_W'(GRID_SIDE)
                                                    : DIM_W'(grid_height_ff);

   assign meta_in.valid = req_tvalid;
   assign meta_in.action = req_tuser;
   assign meta_in.cell_index = req_tdata[15:0];
   assign meta_in.cell_value = req_tdata[23:16];
   assign meta_in.beam_index = req_tdata[35:24];
   assign meta_in.beam_range = req_tdata[59:36];

   bglk_trig #(.MAX_BEAMS(MAX_BEAMS)) u_trig (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .meta_in     (meta_in),
      .start_angle (start_angle_ff),
      .angle_step  (angle_step_ff),
      .meta_out    (meta3),
      .cos_out     (cos_v),
      .sin_out     (sin_v)
   );

   bglk_project #(.GRID_SIDE(GRID_SIDE)) u_project (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .meta_in         (meta3),
      .cos_in          (cos_v),
      .sin_in          (sin_v),
      .offset_x        (offset_x_ff),
      .offset_y        (offset_y_ff),
      .cells_per_meter (cells_per_m_ff),
      .dim_w           (dim_w),
      .dim_h           (dim_h),
      .meta_out        (meta7),
      .col_out         (col7),
      .row_out         (row7),
      .inside_out      (inside7)
   );

   assign raddr = ADDR_W'(32'(col7) + 32'(row7) * 32'(dim_w));
   assign load_we = en && meta7.valid && (meta7.action == ACT_LOAD)
                 && (32'(meta7.cell_index) < DEPTH);

   bglk_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_grid (
      .clock (clock),
      .we    (load_we),
      .waddr (ADDR_W'(32'(meta7.cell_index))),
      .wdata (meta7.cell_value),
      .re    (en),
      .raddr (raddr),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         meta8_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         meta8_ff <= meta7;
         rsp_valid_ff <= meta8_ff.valid && (meta8_ff.action == ACT_BEAM);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside8_ff <= inside7;
         rsp_data_ff <= {3'd0, inside8_ff, inside8_ff ? ram_q : 8'd0, meta8_ff.beam_index};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

[src/bglk_checker.sv]
// ---------------------------------------------------------------------------
// Beam endpoint grid lookup checker
// Port-level checks over time, bound to the top level.
// ---------------------------------------------------------------------------
module bglk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Response valid after reset.");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("Request ready does not follow the output register.");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[20]) |-> (rsp_tdata[19:12] == 8'd0))
      else $error("Occupancy not zero for an endpoint outside the grid.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("Stalled response beat changed.");

endmodule

bind beam_endpoint_grid_lookup bglk_checker u_bglk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
